// ----- design/unsigned_radix_to_ascii_top_defines.svh -----
// Assertion macros used by the converter's top-level RTL file.
// Each macro expects a clock named clk and an active-low reset named rst_n
// in the scope where it is used.
`ifndef UNSIGNED_RADIX_TO_ASCII_TOP_DEFINES_SVH
`define UNSIGNED_RADIX_TO_ASCII_TOP_DEFINES_SVH

// Same-cycle implication.
`define URTA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define URTA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/urta_pkg.sv -----
// ----------------------------------------------------------------------------
// urta_pkg
// Types, codes and character helpers for the unsigned radix to ASCII
// converter.
// ----------------------------------------------------------------------------
package urta_pkg;

    // Default sizing of the converter.
    localparam int URTA_DIGIT_BUFFER_DEPTH = 24;
    localparam int URTA_VALUE_WIDTH        = 64;

    // Field widths fixed by the interface.
    localparam int REQ_VALUE_W = 64;
    localparam int CHAR_W      = 7;

    // Radix modes.
    localparam logic [1:0] MODE_DEC    = 2'd0;
    localparam logic [1:0] MODE_OCT    = 2'd1;
    localparam logic [1:0] MODE_HEX_LO = 2'd2;
    localparam logic [1:0] MODE_HEX_UP = 2'd3;

    // Size codes; the fourth code behaves as the plain 32-bit size.
    localparam logic [1:0] SIZE_INT   = 2'd0;
    localparam logic [1:0] SIZE_LONG  = 2'd1;
    localparam logic [1:0] SIZE_SHORT = 2'd2;

    // ASCII characters used in the output strings.
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_X_LOWER = 7'h78;
    localparam logic [CHAR_W-1:0] CHAR_X_UPPER = 7'h58;
    localparam logic [CHAR_W-1:0] CHAR_A_LOWER = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_A_UPPER = 7'h41;

    // Request and result payloads.
    typedef struct packed {
        logic [REQ_VALUE_W-1:0] value;
        logic [1:0]             mode;
        logic [1:0]             size_code;
        logic                   alternate_form;
    } urta_request_t;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last_char;
    } urta_result_t;

    // Operations of the shared step unit.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_DABBLE,
        OP_SHR3,
        OP_SHR4
    } urta_step_op_t;

    // Control handed from the sequencer to the step unit.
    typedef struct packed {
        urta_step_op_t op;
        logic          two_bits;
    } urta_step_ctrl_t;

    // Maps one digit to its ASCII character.
    function automatic logic [CHAR_W-1:0] urta_digit_char(input logic [3:0] digit,
                                                          input logic       upper);
        logic [CHAR_W-1:0] base_char;
        begin
            base_char = upper ? CHAR_A_UPPER : CHAR_A_LOWER;
            if (digit < 4'd10)
                urta_digit_char = CHAR_ZERO + {3'b000, digit};
            else
                urta_digit_char = base_char + {3'b000, digit - 4'd10};
        end
    endfunction

endpackage

// ----- design/urta_step_unit.sv -----
// ----------------------------------------------------------------------------
// urta_step_unit
// Shared arithmetic step: one or two shift-and-add-3 binary to BCD steps, or a
// three or four bit right shift that peels off the lowest digit.
// ----------------------------------------------------------------------------
module urta_step_unit
    import urta_pkg::*;
#(
    parameter int BCD_DIGITS = 20,
    parameter int BIN_W      = 64
)
(
    input  urta_step_ctrl_t         ctrl,
    input  logic [4*BCD_DIGITS-1:0] bcd_in,
    input  logic [BIN_W-1:0]        bin_in,
    output logic [4*BCD_DIGITS-1:0] bcd_out,
    output logic [BIN_W-1:0]        bin_out,
    output logic [3:0]              digit,
    output logic                    rest_zero
);

    localparam int BCD_W = 4 * BCD_DIGITS;

    logic [BCD_W-1:0] adj_1;
    logic [BCD_W-1:0] adj_2;
    logic [BCD_W-1:0] bcd_1;
    logic [BCD_W-1:0] bcd_2;
    logic [BIN_W-1:0] bin_1;
    logic [BIN_W-1:0] bin_2;

    // Two dabble steps: correct each BCD digit of five or more, then shift
    // the next binary bit in.
    always_comb
    begin
        adj_1 = bcd_in;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (adj_1[4*i +: 4] >= 4'd5)
                adj_1[4*i +: 4] = adj_1[4*i +: 4] + 4'd3;
        end
        {bcd_1, bin_1} = {adj_1, bin_in} << 1;

        adj_2 = bcd_1;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (adj_2[4*i +: 4] >= 4'd5)
                adj_2[4*i +: 4] = adj_2[4*i +: 4] + 4'd3;
        end
        {bcd_2, bin_2} = {adj_2, bin_1} << 1;
    end

    // Operation select.
    always_comb
    begin
        bcd_out   = bcd_in;
        bin_out   = bin_in;
        digit     = bcd_in[3:0];
        rest_zero = 1'b0;
        case (ctrl.op)
            OP_DABBLE:
            begin
                bcd_out = ctrl.two_bits ? bcd_2 : bcd_1;
                bin_out = ctrl.two_bits ? bin_2 : bin_1;
            end
            OP_SHR3:
            begin
                bcd_out   = bcd_in >> 3;
                digit     = {1'b0, bcd_in[2:0]};
                rest_zero = (bcd_out == '0);
            end
            OP_SHR4:
            begin
                bcd_out   = bcd_in >> 4;
                digit     = bcd_in[3:0];
                rest_zero = (bcd_out == '0);
            end
            default:
            begin
                bcd_out = bcd_in;
                bin_out = bin_in;
            end
        endcase
    end

endmodule

// ----- design/urta_digit_store.sv -----
// ----------------------------------------------------------------------------
// urta_digit_store
// Character buffer: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module urta_digit_store
    import urta_pkg::*;
#(
    parameter int DEPTH = 24
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [CHAR_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [CHAR_W-1:0]        rd_data
);

    logic [CHAR_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

// ----- design/unsigned_radix_to_ascii_top.sv -----
// ----------------------------------------------------------------------------
// unsigned_radix_to_ascii_top
// Sequence: decimal values are first converted to BCD over the kept width
//   (16, 32 or VALUE_WIDTH bits); every mode then writes its digits and any
//   prefix to the buffer and reads them back, most significant first.
// Throughput: one character per cycle once output starts; busy stays high
//   until the last character is read from the buffer.
// Reset: asynchronous, active low; clears the sequencer and the strobe.
// The receiver cannot stall; each character is shown for one cycle.
// ----------------------------------------------------------------------------
`include "unsigned_radix_to_ascii_top_defines.svh"

module unsigned_radix_to_ascii_top
    import urta_pkg::*;
#(
    parameter int DIGIT_BUFFER_DEPTH = URTA_DIGIT_BUFFER_DEPTH,
    parameter int VALUE_WIDTH        = URTA_VALUE_WIDTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  urta_request_t request,
    output logic          busy,
    output logic          result_valid,
    output urta_result_t  result
);

    localparam int ADDR_W     = $clog2(DIGIT_BUFFER_DEPTH);
    localparam int CNT_W      = $clog2(DIGIT_BUFFER_DEPTH + 1);
    localparam int BL_W       = $clog2(VALUE_WIDTH + 1);
    localparam int BCD_DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int INT_W      = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

    localparam logic [VALUE_WIDTH-1:0] MASK_SHORT = {VALUE_WIDTH{1'b1}} >> (VALUE_WIDTH - 16);
    localparam logic [VALUE_WIDTH-1:0] MASK_INT   = {VALUE_WIDTH{1'b1}} >> (VALUE_WIDTH - INT_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DABBLE,
        ST_DIGITS,
        ST_PREFIX_X,
        ST_PREFIX_0,
        ST_EMIT
    } state_t;

    state_t              state_reg,        state_next;
    logic [CNT_W-1:0]    count_reg,        count_next;
    logic [ADDR_W-1:0]   rd_idx_reg,       rd_idx_next;
    logic [BL_W-1:0]     bits_left_reg,    bits_left_next;
    logic [1:0]          mode_reg,         mode_next;
    logic                prefix_reg,       prefix_next;
    logic                result_valid_reg, result_valid_next;
    logic                last_char_reg,    last_char_next;
    logic [BCD_W-1:0]    bcd_reg,          bcd_next;
    logic [VALUE_WIDTH-1:0] bin_reg,       bin_next;

    logic [VALUE_WIDTH-1:0] original;
    logic [VALUE_WIDTH-1:0] num;
    logic [VALUE_WIDTH-1:0] num_aligned;
    logic [BL_W-1:0]        num_bits;

    urta_step_ctrl_t     step_ctrl;
    logic [BCD_W-1:0]    step_bcd;
    logic [VALUE_WIDTH-1:0] step_bin;
    logic [3:0]          step_digit;
    logic                step_rest_zero;

    logic                wr_en;
    logic [CHAR_W-1:0]   wr_data;
    logic                rd_en;
    logic [CHAR_W-1:0]   rd_data;

    // Size cut of the incoming value and its alignment for the BCD shifter.
    always_comb
    begin
        original = request.value[VALUE_WIDTH-1:0];
        case (request.size_code)
            SIZE_LONG:
            begin
                num         = original;
                num_bits    = BL_W'(VALUE_WIDTH);
                num_aligned = original;
            end
            SIZE_SHORT:
            begin
                num         = original & MASK_SHORT;
                num_bits    = BL_W'(16);
                num_aligned = num << (VALUE_WIDTH - 16);
            end
            default:
            begin
                num         = original & MASK_INT;
                num_bits    = BL_W'(INT_W);
                num_aligned = num << (VALUE_WIDTH - INT_W);
            end
        endcase
    end

    // Shared step unit.
    urta_step_unit #(
        .BCD_DIGITS (BCD_DIGITS),
        .BIN_W      (VALUE_WIDTH)
    ) u_step (
        .ctrl      (step_ctrl),
        .bcd_in    (bcd_reg),
        .bin_in    (bin_reg),
        .bcd_out   (step_bcd),
        .bin_out   (step_bin),
        .digit     (step_digit),
        .rest_zero (step_rest_zero)
    );

    // Character buffer, filled least significant first.
    urta_digit_store #(
        .DEPTH (DIGIT_BUFFER_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_data)
    );

    // Sequencer next-state logic.
    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        rd_idx_next       = rd_idx_reg;
        bits_left_next    = bits_left_reg;
        mode_next         = mode_reg;
        prefix_next       = prefix_reg;
        bcd_next          = bcd_reg;
        bin_next          = bin_reg;
        last_char_next    = 1'b0;
        step_ctrl.op       = OP_HOLD;
        step_ctrl.two_bits = 1'b0;
        wr_en             = 1'b0;
        wr_data           = CHAR_ZERO;
        rd_en             = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    mode_next   = request.mode;
                    prefix_next = request.alternate_form && (original != '0)
                                  && (request.mode != MODE_DEC);
                    count_next  = '0;
                    if (request.mode == MODE_DEC)
                    begin
                        bcd_next       = '0;
                        bin_next       = num_aligned;
                        bits_left_next = num_bits;
                        state_next     = ST_DABBLE;
                    end
                    else
                    begin
                        bcd_next   = BCD_W'(num);
                        state_next = ST_DIGITS;
                    end
                end
            end

            ST_DABBLE:
            begin
                step_ctrl.op       = OP_DABBLE;
                step_ctrl.two_bits = (bits_left_reg != BL_W'(1));
                bcd_next           = step_bcd;
                bin_next           = step_bin;
                bits_left_next     = bits_left_reg - (step_ctrl.two_bits ? BL_W'(2) : BL_W'(1));
                if (bits_left_reg <= BL_W'(2))
                    state_next = ST_DIGITS;
            end

            ST_DIGITS:
            begin
                step_ctrl.op = (mode_reg == MODE_OCT) ? OP_SHR3 : OP_SHR4;
                bcd_next     = step_bcd;
                wr_en        = 1'b1;
                wr_data      = urta_digit_char(step_digit, mode_reg == MODE_HEX_UP);
                count_next   = count_reg + CNT_W'(1);
                if (step_rest_zero)
                begin
                    if (prefix_reg)
                        state_next = (mode_reg == MODE_OCT) ? ST_PREFIX_0 : ST_PREFIX_X;
                    else
                    begin
                        rd_idx_next = count_reg[ADDR_W-1:0];
                        state_next  = ST_EMIT;
                    end
                end
            end

            ST_PREFIX_X:
            begin
                wr_en      = 1'b1;
                wr_data    = (mode_reg == MODE_HEX_UP) ? CHAR_X_UPPER : CHAR_X_LOWER;
                count_next = count_reg + CNT_W'(1);
                state_next = ST_PREFIX_0;
            end

            ST_PREFIX_0:
            begin
                wr_en       = 1'b1;
                wr_data     = CHAR_ZERO;
                count_next  = count_reg + CNT_W'(1);
                rd_idx_next = count_reg[ADDR_W-1:0];
                state_next  = ST_EMIT;
            end

            ST_EMIT:
            begin
                rd_en          = 1'b1;
                last_char_next = (rd_idx_reg == '0);
                if (rd_idx_reg == '0)
                    state_next = ST_IDLE;
                else
                    rd_idx_next = rd_idx_reg - ADDR_W'(1);
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        result_valid_next = rd_en;
    end

    // Sequencer state and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            rd_idx_reg       <= '0;
            bits_left_reg    <= '0;
            mode_reg         <= MODE_DEC;
            prefix_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
            last_char_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            rd_idx_reg       <= rd_idx_next;
            bits_left_reg    <= bits_left_next;
            mode_reg         <= mode_next;
            prefix_reg       <= prefix_next;
            result_valid_reg <= result_valid_next;
            last_char_reg    <= last_char_next;
        end
    end

    // Working value registers.
    always_ff @(posedge clk)
    begin
        bcd_reg <= bcd_next;
        bin_reg <= bin_next;
    end

    // Outputs.
    assign busy              = (state_reg != ST_IDLE);
    assign result_valid      = result_valid_reg;
    assign result.digit_char = rd_data;
    assign result.last_char  = last_char_reg;

    // Checks.
    `URTA_ASSERT_NXT(a_busy_after_start, start && !busy, busy, "request taken but not busy")
    `URTA_ASSERT_NXT(a_emit_strobe, state_reg == ST_EMIT, result_valid, "buffer read gave no strobe")
    `URTA_ASSERT_IMP(a_count_in_range, 1'b1, count_reg <= CNT_W'(DIGIT_BUFFER_DEPTH), "character count past buffer depth")
    `URTA_ASSERT_IMP(a_last_ends_emit, result_valid && result.last_char, state_reg != ST_EMIT, "last character shown while still reading")
    `URTA_ASSERT_IMP(a_dabble_bits, state_reg == ST_DABBLE, bits_left_reg != '0, "BCD conversion with no bits left")

endmodule
